FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; empty when building for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Clocked property, disabled while reset is held low
`define AR_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);
// Clocked property, checked during reset as well
`define AR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AR_ASSERT(lbl, clk, rstn, prop, msg)
`define AR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: rtl/arpr_pkg.sv
// ----------------------------------------------------------------------------
// ARP responder package
// Field widths, request and result layouts, status codes and control bundles.
// ----------------------------------------------------------------------------
package arpr_pkg;

    localparam int unsigned TABLE_ENTRIES_DEF = 8;

    localparam int unsigned OPC_W    = 16;
    localparam int unsigned MAC_W    = 48;
    localparam int unsigned IP_W     = 32;
    localparam int unsigned PORT_W   = 8;
    localparam int unsigned STATUS_W = 3;

    localparam int unsigned S_TDATA_W = 216;
    localparam int unsigned M_TDATA_W = 184;

    localparam logic [OPC_W-1:0] ARP_OP_REQUEST = 16'h0001;
    localparam logic [OPC_W-1:0] ARP_OP_REPLY   = 16'h0002;

    // tuser on the request side
    localparam logic OPC_ADD_BINDING = 1'b0;
    localparam logic OPC_ARP_HEADER  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_REPLY   = 3'd0,
        ST_NOMATCH = 3'd1,
        ST_IGNORED = 3'd2,
        ST_UNKNOWN = 3'd3,
        ST_ADDED   = 3'd4,
        ST_FULL    = 3'd5
    } status_t;

    // Request payload; the last field declared, arp_opcode, sits in the lowest bits
    typedef struct packed {
        logic [MAC_W-1:0]  entry_mac;
        logic [IP_W-1:0]   entry_ip;
        logic [PORT_W-1:0] port_index;
        logic [IP_W-1:0]   target_ip;
        logic [IP_W-1:0]   sender_ip;
        logic [MAC_W-1:0]  sender_mac;
        logic [OPC_W-1:0]  arp_opcode;
    } item_t;

    // Result payload; the last field declared, reply_opcode, sits in the lowest bits
    typedef struct packed {
        logic [PORT_W-1:0] out_port;
        logic [IP_W-1:0]   reply_target_ip;
        logic [MAC_W-1:0]  reply_target_mac;
        logic [IP_W-1:0]   reply_sender_ip;
        logic [MAC_W-1:0]  reply_sender_mac;
        logic [OPC_W-1:0]  reply_opcode;
    } result_t;

    // Controller to datapath
    typedef struct packed {
        logic load;    // capture the request, rewind the table walk
        logic rd_en;   // read the current table entry and advance
        logic commit;  // write the result, update the table
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free; // result register can take a new result this cycle
        logic rd_last;  // current read address is the final table entry
    } sts_t;

endpackage

FILE: rtl/arp_request_responder.sv
// ----------------------------------------------------------------------------
// ARP request responder
// Answers ARP requests for local interface addresses from a binding table.
// ----------------------------------------------------------------------------
// Each request on the s_ channel is either an add-binding command (s_tuser 0)
// or a parsed ARP header (s_tuser 1), and yields exactly one result on the m_
// channel, with its status in m_tuser. An add overwrites the valid binding
// that has the same IP, else takes the lowest free slot, else reports the
// table full and leaves it unchanged. An ARP request (operation 1) whose
// target IP is bound yields a reply: operation 2, the bound MAC as sender,
// the addresses swapped and the arrival port as output port. ARP replies are
// ignored and other operations reported as unknown; for every status other
// than "reply made" the result payload is all zero. Hardware and protocol
// type are not checked. The table is walked one entry per cycle through a
// single read port, and one request occupies the block from acceptance to
// the next acceptance (capture, a read of every entry, final compare,
// commit). A finished result waits in an output register, so the next
// request is accepted while it is still untaken; commit stalls only while
// that register is still full.
// ----------------------------------------------------------------------------
module arp_request_responder
    import arpr_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // request channel
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // arp_opcode, sender_mac, sender_ip, target_ip, port_index, entry_ip, entry_mac
    input  logic [S_TDATA_W-1:0] s_tdata,
    // opcode (0 add binding, 1 ARP header)
    input  logic                 s_tuser,
    // result channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // reply_opcode, reply_sender_mac, reply_sender_ip, reply_target_mac,
    // reply_target_ip, out_port
    output logic [M_TDATA_W-1:0] m_tdata,
    // status
    output logic [STATUS_W-1:0]  m_tuser
);

    cmd_t cmd;
    sts_t sts;

    // Sequence each request: capture, walk the table, resolve, commit
    arpr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Hold the table, compare each entry and drive the result register
    arpr_dpath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_opcode (s_tuser),
        .s_data   (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

FILE: rtl/arpr_ctrl.sv
// ----------------------------------------------------------------------------
// ARP responder controller
// Sequences capture, table walk, final compare and result commit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module arpr_ctrl
    import arpr_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_COMMIT
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.rd_en = 1'b1;
                if (sts.rd_last) begin
                    state_next = S_DRAIN;
                end
            end
            // last read data is compared here
            S_DRAIN: begin
                state_next = S_COMMIT;
            end
            S_COMMIT: begin
                if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `AR_ASSERT(a_commit_free, aclk, aresetn, cmd.commit |-> sts.out_free, "commit into busy output")
    `AR_ASSERT(a_load_walk, aclk, aresetn, cmd.load |=> cmd.rd_en, "walk did not follow capture")
    `AR_ASSERT(a_walk_end, aclk, aresetn, (cmd.rd_en && sts.rd_last) |=> !cmd.rd_en, "walk ran past table")

endmodule

FILE: rtl/arpr_dpath.sv
// ----------------------------------------------------------------------------
// ARP responder datapath
// Binding table, one-entry-per-cycle lookup and the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module arpr_dpath
    import arpr_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cmd_t                 cmd,
    output sts_t                 sts,
    input  logic                 s_opcode,
    input  logic [S_TDATA_W-1:0] s_data,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [STATUS_W-1:0]  m_tuser
);

    localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    // Binding table
    logic [IP_W-1:0]          ip_mem  [TABLE_ENTRIES];
    logic [MAC_W-1:0]         mac_mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;

    // Captured request
    logic  opcode_reg;
    item_t item_reg;

    // Table walk
    logic [IDX_W-1:0] rd_addr_reg, rd_addr_next;
    logic             rd_pend_reg, rd_pend_next;
    logic [IDX_W-1:0] rd_idx_reg;
    logic [IP_W-1:0]  ip_rd_reg;
    logic [MAC_W-1:0] mac_rd_reg;

    // Search results
    logic             hit_found_reg, hit_found_next;
    logic [IDX_W-1:0] hit_idx_reg;
    logic [MAC_W-1:0] hit_mac_reg;
    logic             free_found_reg, free_found_next;
    logic [IDX_W-1:0] free_idx_reg;

    // Result register
    logic             out_valid_reg, out_valid_next;
    status_t          out_status_reg;
    result_t          out_data_reg;

    logic [IP_W-1:0]  key_ip;
    logic             hit_now;
    logic             free_now;
    logic             add_ok;
    logic [IDX_W-1:0] wr_idx;
    status_t          status_new;
    result_t          data_new;

    assign key_ip   = (opcode_reg == OPC_ADD_BINDING) ? item_reg.entry_ip : item_reg.target_ip;
    assign hit_now  = rd_pend_reg && valid_reg[rd_idx_reg] && (ip_rd_reg == key_ip)
                      && !hit_found_reg;
    assign free_now = rd_pend_reg && !valid_reg[rd_idx_reg] && !free_found_reg;

    assign add_ok = hit_found_reg || free_found_reg;
    assign wr_idx = hit_found_reg ? hit_idx_reg : free_idx_reg;

    assign sts.out_free = !out_valid_reg || m_tready;
    assign sts.rd_last  = (rd_addr_reg == LAST_IDX);

    // Resolve the result from the finished walk
    always_comb begin
        data_new = '0;
        if (opcode_reg == OPC_ADD_BINDING) begin
            status_new = add_ok ? ST_ADDED : ST_FULL;
        end else if (item_reg.arp_opcode == ARP_OP_REQUEST) begin
            if (hit_found_reg) begin
                status_new                = ST_REPLY;
                data_new.reply_opcode     = ARP_OP_REPLY;
                data_new.reply_sender_mac = hit_mac_reg;
                data_new.reply_sender_ip  = item_reg.target_ip;
                data_new.reply_target_mac = item_reg.sender_mac;
                data_new.reply_target_ip  = item_reg.sender_ip;
                data_new.out_port         = item_reg.port_index;
            end else begin
                status_new = ST_NOMATCH;
            end
        end else if (item_reg.arp_opcode == ARP_OP_REPLY) begin
            status_new = ST_IGNORED;
        end else begin
            status_new = ST_UNKNOWN;
        end
    end

    always_comb begin
        rd_addr_next    = rd_addr_reg;
        rd_pend_next    = cmd.rd_en;
        hit_found_next  = hit_found_reg || hit_now;
        free_found_next = free_found_reg || free_now;
        valid_next      = valid_reg;
        out_valid_next  = out_valid_reg;
        if (cmd.load) begin
            rd_addr_next    = '0;
            hit_found_next  = 1'b0;
            free_found_next = 1'b0;
        end else if (cmd.rd_en) begin
            rd_addr_next = rd_addr_reg + IDX_W'(1);
        end
        if (cmd.commit && (opcode_reg == OPC_ADD_BINDING) && add_ok) begin
            valid_next[wr_idx] = 1'b1;
        end
        if (cmd.commit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= '0;
            rd_addr_reg    <= '0;
            rd_pend_reg    <= 1'b0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            valid_reg      <= valid_next;
            rd_addr_reg    <= rd_addr_next;
            rd_pend_reg    <= rd_pend_next;
            hit_found_reg  <= hit_found_next;
            free_found_reg <= free_found_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            opcode_reg <= s_opcode;
            item_reg   <= item_t'(s_data);
        end
        if (cmd.rd_en) begin
            rd_idx_reg <= rd_addr_reg;
        end
        if (hit_now) begin
            hit_idx_reg <= rd_idx_reg;
            hit_mac_reg <= mac_rd_reg;
        end
        if (free_now) begin
            free_idx_reg <= rd_idx_reg;
        end
        if (cmd.commit) begin
            out_status_reg <= status_new;
            out_data_reg   <= data_new;
        end
    end

    // Table memories: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.commit && (opcode_reg == OPC_ADD_BINDING) && add_ok) begin
            ip_mem[wr_idx]  <= item_reg.entry_ip;
            mac_mem[wr_idx] <= item_reg.entry_mac;
        end
        if (cmd.rd_en) begin
            ip_rd_reg  <= ip_mem[rd_addr_reg];
            mac_rd_reg <= mac_mem[rd_addr_reg];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;

    `AR_ASSERT(a_valid_grow, aclk, aresetn, $countones(valid_reg) >= $past($countones(valid_reg)), "binding lost")
    `AR_ASSERT(a_reply_op, aclk, aresetn, (out_valid_reg && out_status_reg == ST_REPLY) |-> (out_data_reg.reply_opcode == ARP_OP_REPLY), "reply without op 2")
    `AR_ASSERT(a_noreply_zero, aclk, aresetn, (out_valid_reg && out_status_reg != ST_REPLY) |-> (out_data_reg == '0), "non-reply carries data")

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ARP request responder testbench
// Drives add-binding commands and ARP headers into the responder under random
// back-pressure on both channels. A scoreboard class keeps its own binding
// table, predicts the status and reply for each accepted request, and checks
// every result field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;
    import arpr_pkg::*;

    localparam int unsigned ENTRIES     = TABLE_ENTRIES_DEF;
    localparam int unsigned RANDOM_REQS = 700;
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned IDLE_PCT    = 17;

    // ------------------------------------------------------------------------
    // Scoreboard: binding table copy and queue of expected responses
    // ------------------------------------------------------------------------
    class arp_scoreboard;
        logic [IP_W-1:0]  if_ip   [ENTRIES];
        logic [MAC_W-1:0] if_mac  [ENTRIES];
        bit               if_used [ENTRIES];
        status_t          want_status  [$];
        result_t          want_payload [$];
        int unsigned      errors;
        int unsigned      seen;

        function new();
            for (int i = 0; i < ENTRIES; i++) begin
                if_ip[i]   = '0;
                if_mac[i]  = '0;
                if_used[i] = 1'b0;
            end
            errors = 0;
            seen   = 0;
        endfunction

        function int lookup(input logic [IP_W-1:0] ip);
            for (int i = 0; i < ENTRIES; i++)
                if (if_used[i] && if_ip[i] == ip) return i;
            return -1;
        endfunction

        function int first_free();
            for (int i = 0; i < ENTRIES; i++)
                if (!if_used[i]) return i;
            return -1;
        endfunction

        function int pending();
            return want_status.size();
        endfunction

        // Predict the response to one accepted request and queue it
        function void note_request(input logic op, input item_t it);
            int      idx;
            status_t st;
            result_t res;
            res = '0;
            if (op == OPC_ADD_BINDING) begin
                idx = lookup(it.entry_ip);
                if (idx < 0) idx = first_free();
                if (idx < 0) begin
                    st = ST_FULL;
                end else begin
                    if_ip[idx]   = it.entry_ip;
                    if_mac[idx]  = it.entry_mac;
                    if_used[idx] = 1'b1;
                    st = ST_ADDED;
                end
            end else if (it.arp_opcode == ARP_OP_REQUEST) begin
                idx = lookup(it.target_ip);
                if (idx < 0) begin
                    st = ST_NOMATCH;
                end else begin
                    st = ST_REPLY;
                    res.reply_opcode     = ARP_OP_REPLY;
                    res.reply_sender_mac = if_mac[idx];
                    res.reply_sender_ip  = it.target_ip;
                    res.reply_target_mac = it.sender_mac;
                    res.reply_target_ip  = it.sender_ip;
                    res.out_port         = it.port_index;
                end
            end else if (it.arp_opcode == ARP_OP_REPLY) begin
                st = ST_IGNORED;
            end else begin
                st = ST_UNKNOWN;
            end
            want_status.push_back(st);
            want_payload.push_back(res);
        endfunction

        task report_mismatch(input string what, input logic [63:0] got,
                             input logic [63:0] want);
            $display("result %0d: %s got %h, expected %h", seen, what, got, want);
            errors++;
        endtask

        task check_result(input logic [STATUS_W-1:0] st, input result_t got);
            status_t ws;
            result_t wp;
            seen++;
            if (want_status.size() == 0) begin
                report_mismatch("unexpected result, status", 64'(st), '0);
                return;
            end
            ws = want_status.pop_front();
            wp = want_payload.pop_front();
            if (st !== ws)
                report_mismatch("status", 64'(st), 64'(ws));
            if (got.reply_opcode !== wp.reply_opcode)
                report_mismatch("reply_opcode", 64'(got.reply_opcode),
                                64'(wp.reply_opcode));
            if (got.reply_sender_mac !== wp.reply_sender_mac)
                report_mismatch("reply_sender_mac", 64'(got.reply_sender_mac),
                                64'(wp.reply_sender_mac));
            if (got.reply_sender_ip !== wp.reply_sender_ip)
                report_mismatch("reply_sender_ip", 64'(got.reply_sender_ip),
                                64'(wp.reply_sender_ip));
            if (got.reply_target_mac !== wp.reply_target_mac)
                report_mismatch("reply_target_mac", 64'(got.reply_target_mac),
                                64'(wp.reply_target_mac));
            if (got.reply_target_ip !== wp.reply_target_ip)
                report_mismatch("reply_target_ip", 64'(got.reply_target_ip),
                                64'(wp.reply_target_ip));
            if (got.out_port !== wp.out_port)
                report_mismatch("out_port", 64'(got.out_port), 64'(wp.out_port));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block under test
    // ------------------------------------------------------------------------
    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]  m_tuser;

    // no idling on either side while set
    bit calm = 1'b0;

    arp_scoreboard sb = new();

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    arp_request_responder #(
        .TABLE_ENTRIES(ENTRIES)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // ------------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------------
    function automatic item_t noise_item();
        item_t       it;
        logic [63:0] r;
        r = {$urandom, $urandom};
        it.arp_opcode = r[15:0];
        r = {$urandom, $urandom};
        it.sender_mac = r[47:0];
        it.sender_ip  = $urandom;
        it.target_ip  = $urandom;
        it.port_index = PORT_W'($urandom_range(0, 255));
        it.entry_ip   = $urandom;
        r = {$urandom, $urandom};
        it.entry_mac  = r[47:0];
        return it;
    endfunction

    function automatic logic [IP_W-1:0] known_ip();
        return sb.if_ip[$urandom_range(0, ENTRIES - 1)];
    endfunction

    // Present one request, hold it until taken, then note it for prediction.
    // Handshakes are sampled at the falling edge, where all signals are settled.
    task automatic send_request(input logic op, input item_t it);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= it;
        s_tuser  <= op;
        @(negedge aclk);
        while (!s_tready) @(negedge aclk);
        @(posedge aclk);
        sb.note_request(op, it);
    endtask

    task automatic send_add(input logic [IP_W-1:0] ip, input logic [MAC_W-1:0] mac);
        item_t it;
        it = noise_item();
        it.entry_ip  = ip;
        it.entry_mac = mac;
        send_request(OPC_ADD_BINDING, it);
    endtask

    task automatic send_arp(input logic [OPC_W-1:0] opc, input logic [MAC_W-1:0] smac,
                            input logic [IP_W-1:0] sip, input logic [IP_W-1:0] tip,
                            input logic [PORT_W-1:0] port);
        item_t it;
        it = noise_item();
        it.arp_opcode = opc;
        it.sender_mac = smac;
        it.sender_ip  = sip;
        it.target_ip  = tip;
        it.port_index = port;
        send_request(OPC_ARP_HEADER, it);
    endtask

    // ------------------------------------------------------------------------
    // Result side: random back-pressure, check each response as it is taken
    // ------------------------------------------------------------------------
    initial begin
        forever begin
            @(posedge aclk);
            m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(negedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata);
    end

    // Drop the run if nothing moves on either channel for too long
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(negedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int unsigned u;
        item_t       it;
        logic        op;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty table: reset IP of zero must not match
        send_arp(ARP_OP_REQUEST, 48'h0, 32'h0, 32'h0, 8'h0);
        send_arp(ARP_OP_REPLY, 48'h0a0b0c0d0e0f, 32'hc0a80001, 32'hc0a80002, 8'h3);
        send_arp(16'h0000, 48'h1, 32'h1, 32'h1, 8'h1);
        send_arp(16'h0003, 48'h2, 32'h2, 32'h2, 8'h2);
        send_arp(16'hffff, 48'hffffffffffff, 32'hffffffff, 32'hffffffff, 8'hff);
        // Extremes of the binding and header fields
        send_add(32'h0, 48'hffffffffffff);
        send_arp(ARP_OP_REQUEST, 48'hffffffffffff, 32'hffffffff, 32'h0, 8'hff);
        send_add(32'hffffffff, 48'h0);
        send_arp(ARP_OP_REQUEST, 48'h0, 32'h0, 32'hffffffff, 8'h0);
        // Overwrite of an existing binding
        send_add(32'h0, 48'h0123456789ab);
        send_arp(ARP_OP_REQUEST, 48'h5a5a5a5a5a5a, 32'h0a0a0a0a, 32'h0, 8'h80);
        // Fill the remaining slots
        for (int k = 1; k <= ENTRIES - 2; k++)
            send_add(32'h0a000000 + 32'(k), 48'h020000000000 + 48'(k));
        // Full table: new IP refused, known IP still overwritten
        send_add(32'h0a000063, 48'h0200000000ff);
        send_add(32'h0a000003, 48'hfedcba987654);
        send_arp(ARP_OP_REQUEST, 48'h111111111111, 32'h22222222, 32'h0a000063, 8'h7);
        send_arp(ARP_OP_REQUEST, 48'h333333333333, 32'h44444444, 32'h0a000003, 8'h55);
        send_arp(ARP_OP_REPLY, 48'h333333333333, 32'h44444444, 32'h0a000003, 8'h55);

        for (int n = 0; n < RANDOM_REQS; n++) begin
            calm = (n >= 250 && n < 400);
            it = noise_item();
            op = OPC_ARP_HEADER;
            u  = $urandom_range(0, 99);
            if (u < 15) begin
                op = OPC_ADD_BINDING;
                if ($urandom_range(0, 99) < 60) it.entry_ip = known_ip();
            end else if (u < 70) begin
                it.arp_opcode = ARP_OP_REQUEST;
                if ($urandom_range(0, 99) < 70) it.target_ip = known_ip();
            end else if (u < 80) begin
                it.arp_opcode = ARP_OP_REPLY;
            end
            // remaining cases keep the random operation code
            send_request(op, it);
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (2 * (ENTRIES + 3)) @(posedge aclk);
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
